[design/xxtea_pkg.sv]
package xxtea_pkg;

  // Data path
  localparam int unsigned DATA_W = 32;
  localparam logic [DATA_W-1:0] DELTA = 32'h9e37_79b9;

  // Key register file
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

  // Round count: block length fits 7 bits, at most 32 rounds for n >= 2
  localparam int unsigned LEN_W = 7;
  localparam int unsigned ROUNDS_W = 6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP0,
    ST_SETUP1,
    ST_SETUP2,
    ST_ROUND,
    ST_EMIT
  } state_e;

  // Operands of one mixing step
  typedef struct packed {
    logic              dec;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] cur;
  } mix_op_t;

  // 6 + 52/n for n >= 2 as a compare ladder
  function automatic logic [ROUNDS_W-1:0] rounds_for(input logic [LEN_W-1:0] n);
    logic [ROUNDS_W-1:0] r;
    if (n <= 7'd2) begin
      r = 6'd32;
    end else if (n == 7'd3) begin
      r = 6'd23;
    end else if (n == 7'd4) begin
      r = 6'd19;
    end else if (n == 7'd5) begin
      r = 6'd16;
    end else if (n == 7'd6) begin
      r = 6'd14;
    end else if (n == 7'd7) begin
      r = 6'd13;
    end else if (n == 7'd8) begin
      r = 6'd12;
    end else if (n <= 7'd10) begin
      r = 6'd11;
    end else if (n <= 7'd13) begin
      r = 6'd10;
    end else if (n <= 7'd17) begin
      r = 6'd9;
    end else if (n <= 7'd26) begin
      r = 6'd8;
    end else if (n <= 7'd52) begin
      r = 6'd7;
    end else begin
      r = 6'd6;
    end
    return r;
  endfunction

endpackage

[design/xxtea_if.sv]
// Input word channel
interface xxtea_in_if;
  import xxtea_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [DATA_W-1:0] data_word;
  logic              last_word;

  modport source (output valid, mode, data_word, last_word, input ready);
  modport sink   (input valid, mode, data_word, last_word, output ready);
endinterface

// Result word channel
interface xxtea_out_if;
  import xxtea_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_word;
  logic              result_last;
  logic              overflow;

  modport source (output valid, result_word, result_last, overflow, input ready);
  modport sink   (input valid, result_word, result_last, overflow, output ready);
endinterface

[design/xxtea_mix.sv]
// One XXTEA mixing step: cur +/- MX(y, z, sum, key)
module xxtea_mix (
  input  xxtea_pkg::mix_op_t              op_i,
  output logic [xxtea_pkg::DATA_W-1:0]    res_o
);
  import xxtea_pkg::*;

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] mx;

  assign a  = ((op_i.z >> 5) ^ (op_i.y << 2)) + ((op_i.y >> 3) ^ (op_i.z << 4));
  assign b  = (op_i.sum ^ op_i.y) + (op_i.key ^ op_i.z);
  assign mx = a ^ b;

  assign res_o = op_i.dec ? (op_i.cur - mx) : (op_i.cur + mx);

endmodule

[design/xxtea_block_cipher.sv]
// Channel  Dir  Handshake      Payload
// req_i    in   valid/ready    mode, data_word, last_word
// res_o    out  valid/ready    result_word, result_last, overflow
// cfg      in   cfg_we_i only  cfg_idx_i (key word), cfg_data_i
//
// Each word of a block is taken in one cycle. After the last word the block
// runs states SETUP0, SETUP1 and SETUP2, then one mixing step per cycle
// through the shared mix unit and the block store (separate write and read
// ports). Results leave one word per cycle while res_o is ready; a one-word
// block skips the rounds. req_i.ready is low from the last word until the
// final result is taken. Reset is asynchronous; the store is not cleared.
module xxtea_block_cipher #(
  parameter int unsigned MAX_WORDS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  xxtea_in_if.sink                           req_i,
  xxtea_out_if.source                        res_o,
  input  logic                               cfg_we_i,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [xxtea_pkg::DATA_W-1:0]       cfg_data_i
);
  import xxtea_pkg::*;

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  // Control state
  state_e                state_q, state_d;
  logic [CW-1:0]         count_q;
  logic                  mode_q;
  logic                  ovf_q;
  logic [ROUNDS_W-1:0]   rounds_q;
  logic [AW-1:0]         p_q;
  logic [AW-1:0]         rp_q;
  logic [AW-1:0]         k_q;
  logic [DATA_W-1:0]     key_q [KEY_WORDS];

  // Step data
  logic [DATA_W-1:0]     carry_q;
  logic [DATA_W-1:0]     cur_q;
  logic [DATA_W-1:0]     sum_q;

  // Block store
  logic [DATA_W-1:0]     mem [MAX_WORDS];
  logic [DATA_W-1:0]     rd_q;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_W-1:0]     mem_wdata;

  logic                  in_acc;
  logic                  out_acc;
  logic                  full;
  logic [AW-1:0]         last_idx;
  logic [AW-1:0]         rp_next;
  logic [AW-1:0]         p_start;
  logic [AW-1:0]         first_fresh;
  logic                  round_end;
  logic                  final_step;
  logic                  emit_last;
  logic [1:0]            key_sel;
  mix_op_t               mix_op;
  logic [DATA_W-1:0]     mix_res;

  assign in_acc   = req_i.valid & req_i.ready;
  assign out_acc  = res_o.valid & res_o.ready;
  assign full     = (count_q == CW'(MAX_WORDS));
  assign last_idx = AW'(count_q - CW'(1));

  // Step pointers: encrypt walks up, decrypt walks down, both wrap at n
  assign p_start     = mode_q ? last_idx : '0;
  assign first_fresh = mode_q ? AW'(count_q - CW'(2)) : AW'(1);
  assign rp_next     = mode_q ? ((rp_q == '0) ? last_idx : rp_q - AW'(1))
                              : ((rp_q == last_idx) ? '0 : rp_q + AW'(1));
  assign round_end   = mode_q ? (p_q == '0) : (p_q == last_idx);
  assign final_step  = round_end && (rounds_q == ROUNDS_W'(1));
  assign emit_last   = (k_q == last_idx);

  // Mix operands: fresh word from the store, chained word from the carry
  assign key_sel      = 2'(p_q) ^ sum_q[3:2];
  assign mix_op.dec   = mode_q;
  assign mix_op.y     = mode_q ? carry_q : rd_q;
  assign mix_op.z     = mode_q ? rd_q : carry_q;
  assign mix_op.sum   = sum_q;
  assign mix_op.key   = key_q[key_sel];
  assign mix_op.cur   = cur_q;

  xxtea_mix u_mix (
    .op_i  (mix_op),
    .res_o (mix_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && req_i.last_word) begin
          state_d = (count_q == '0) ? ST_EMIT : ST_SETUP0;
        end
      end
      ST_SETUP0: state_d = ST_SETUP1;
      ST_SETUP1: state_d = ST_SETUP2;
      ST_SETUP2: state_d = ST_ROUND;
      ST_ROUND: begin
        if (final_step) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && emit_last) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Handshakes and store access
  always_comb begin
    req_i.ready = 1'b0;
    res_o.valid = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = req_i.data_word;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    unique case (state_q)
      ST_LOAD: begin
        req_i.ready = 1'b1;
        if (in_acc && !full) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(count_q);
        end
        // one-word block: fetch it back right away
        if (in_acc && req_i.last_word && count_q == '0) begin
          mem_re = 1'b1;
        end
      end
      ST_SETUP0: begin
        mem_re    = 1'b1;
        mem_raddr = mode_q ? '0 : last_idx;
      end
      ST_SETUP1: begin
        mem_re    = 1'b1;
        mem_raddr = mode_q ? last_idx : '0;
      end
      ST_SETUP2: begin
        mem_re    = 1'b1;
        mem_raddr = first_fresh;
      end
      ST_ROUND: begin
        mem_we    = 1'b1;
        mem_waddr = p_q;
        mem_wdata = mix_res;
        mem_re    = 1'b1;
        mem_raddr = final_step ? '0 : rp_next;
      end
      ST_EMIT: begin
        res_o.valid = 1'b1;
        if (out_acc && !emit_last) begin
          mem_re    = 1'b1;
          mem_raddr = k_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign res_o.result_word = rd_q;
  assign res_o.result_last = emit_last;
  assign res_o.overflow    = ovf_q;

  // Block store, write-first on a same-address read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= (mem_we && mem_waddr == mem_raddr) ? mem_wdata : mem[mem_raddr];
    end
  end

  // Control registers and keys
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      mode_q   <= 1'b0;
      ovf_q    <= 1'b0;
      rounds_q <= '0;
      p_q      <= '0;
      rp_q     <= '0;
      k_q      <= '0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KEY0: key_q[0] <= cfg_data_i;
          REG_KEY1: key_q[1] <= cfg_data_i;
          REG_KEY2: key_q[2] <= cfg_data_i;
          REG_KEY3: key_q[3] <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            if (count_q == '0) begin
              mode_q <= req_i.mode;
            end
            if (!full) begin
              count_q <= count_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            k_q <= '0;
          end
        end
        ST_SETUP0: rounds_q <= rounds_for(LEN_W'(count_q));
        ST_SETUP1: ;
        ST_SETUP2: begin
          rp_q <= first_fresh;
          p_q  <= p_start;
        end
        ST_ROUND: begin
          rp_q <= rp_next;
          if (round_end) begin
            rounds_q <= rounds_q - ROUNDS_W'(1);
            p_q      <= p_start;
          end else begin
            p_q <= mode_q ? p_q - AW'(1) : p_q + AW'(1);
          end
          if (final_step) begin
            k_q <= '0;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (emit_last) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
            end else begin
              k_q <= k_q + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Step data: carry chain, current word and round sum
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_SETUP1: begin
        carry_q <= rd_q;
        sum_q   <= mode_q ? (DELTA * DATA_W'(rounds_q)) : DELTA;
      end
      ST_SETUP2: cur_q <= rd_q;
      ST_ROUND: begin
        carry_q <= mix_res;
        cur_q   <= rd_q;
        if (round_end) begin
          sum_q <= mode_q ? (sum_q - DELTA) : (sum_q + DELTA);
        end
      end
      ST_LOAD, ST_SETUP0, ST_EMIT: ;
      default: ;
    endcase
  end

endmodule

[design/xxtea_chk.sv]
// Port-level checks for the cipher engine
module xxtea_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [31:0] out_word
);

  // no new request is taken while results are being delivered
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("request accepted while results pending");

  // closing a block stops intake on the next cycle
  a_close_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("intake still open after block close");

  // the final result ends the output burst
  a_last_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result shown after final word");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind xxtea_block_cipher xxtea_chk u_xxtea_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .in_last   (req_i.last_word),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_last  (res_o.result_last),
  .out_word  (res_o.result_word)
);

[tb/xxtea_result_checker.sv]
`timescale 1ns / 100ps
module xxtea_result_checker #(
  parameter int unsigned MAX_WORDS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  xxtea_in_if                          req,
  xxtea_out_if                         res,
  input  logic                         cfg_we_i,
  input  logic [xxtea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [xxtea_pkg::DATA_W-1:0] cfg_data_i,
  output int                           mismatches_o,
  output int                           pending_o
);
  import xxtea_pkg::*;

  localparam int unsigned PRINT_CAP = 100;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              last;
    logic              ovf;
  } cipher_word_t;

  // Shadow of the key registers and of the block being loaded
  logic [DATA_W-1:0] cipher_key [KEY_WORDS];
  logic [DATA_W-1:0] held [MAX_WORDS];
  int                held_cnt;
  logic              held_decrypt;
  logic              held_ovf;

  // Result words still owed by the block, oldest first
  cipher_word_t cipher_out_q [$];
  int           fail_cnt = 0;

  assign mismatches_o = fail_cnt;

  task automatic report_mismatch(input string what);
    fail_cnt++;
    if (fail_cnt <= PRINT_CAP) begin
      $display("[%0t] xxtea mismatch: %s", $time, what);
    end
  endtask

  // One XXTEA mixing term
  function automatic logic [DATA_W-1:0] mix_term(input logic [DATA_W-1:0] y,
                                                 input logic [DATA_W-1:0] z,
                                                 input logic [DATA_W-1:0] s,
                                                 input int p,
                                                 input logic [1:0] e);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [1:0]        ki;
    ki = p[1:0] ^ e;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (s ^ y) + (cipher_key[ki] ^ z);
    return a ^ b;
  endfunction

  function automatic void encipher_held(input int n);
    int                rounds;
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [1:0]        e;
    rounds = 6 + 52 / n;
    s = '0;
    z = held[n-1];
    repeat (rounds) begin
      s += DELTA;
      e = s[3:2];
      for (int p = 0; p < n - 1; p++) begin
        y = held[p+1];
        held[p] += mix_term(y, z, s, p, e);
        z = held[p];
      end
      y = held[0];
      held[n-1] += mix_term(y, z, s, n - 1, e);
      z = held[n-1];
    end
  endfunction

  function automatic void decipher_held(input int n);
    int                rounds;
    logic [DATA_W-1:0] s;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [1:0]        e;
    rounds = 6 + 52 / n;
    s = 32'(rounds) * DELTA;
    y = held[0];
    repeat (rounds) begin
      e = s[3:2];
      for (int p = n - 1; p > 0; p--) begin
        z = held[p-1];
        held[p] -= mix_term(y, z, s, p, e);
        y = held[p];
      end
      z = held[n-1];
      held[0] -= mix_term(y, z, s, 0, e);
      y = held[0];
      s -= DELTA;
    end
  endfunction

  // Take one request word; a closing word produces the whole result block
  function automatic void absorb_word(input logic m, input logic [DATA_W-1:0] w,
                                     input logic l);
    int           n;
    cipher_word_t r;
    if (held_cnt == 0) held_decrypt = m;
    if (held_cnt < MAX_WORDS) begin
      held[held_cnt] = w;
      held_cnt++;
    end else begin
      held_ovf = 1'b1;
    end
    if (l) begin
      n = held_cnt;
      // a one-word block passes through untouched
      if (n > 1) begin
        if (held_decrypt) decipher_held(n);
        else encipher_held(n);
      end
      for (int k = 0; k < n; k++) begin
        r.word = held[k];
        r.last = (k == n - 1);
        r.ovf  = held_ovf;
        cipher_out_q.push_back(r);
      end
      held_cnt = 0;
      held_ovf = 1'b0;
    end
  endfunction

  // Watch both channels and the key port
  always @(posedge clk_i or negedge rst_ni) begin
    cipher_word_t want;
    if (!rst_ni) begin
      foreach (cipher_key[i]) cipher_key[i] = '0;
      foreach (held[i]) held[i] = '0;
      held_cnt     = 0;
      held_decrypt = 1'b0;
      held_ovf     = 1'b0;
      cipher_out_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) cipher_key[cfg_idx_i] = cfg_data_i;
      if (res.valid && res.ready) begin
        if (cipher_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", res.result_word));
        end else begin
          want = cipher_out_q.pop_front();
          if (res.result_word !== want.word)
            report_mismatch($sformatf("result_word %h, want %h", res.result_word, want.word));
          if (res.result_last !== want.last)
            report_mismatch($sformatf("result_last %b, want %b", res.result_last, want.last));
          if (res.overflow !== want.ovf)
            report_mismatch($sformatf("overflow %b, want %b", res.overflow, want.ovf));
        end
      end
      if (req.valid && req.ready) absorb_word(req.mode, req.data_word, req.last_word);
      pending_o <= cipher_out_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
  import xxtea_pkg::*;

  localparam int unsigned CAP         = 16;
  localparam int          WORD_TARGET = 370;
  localparam int          QUIET_FROM  = 310;
  localparam int          PHASE_WORDS = 60;
  localparam int          STALL_LIMIT = 4000;
  localparam logic        MODE_ENC    = 1'b0;
  localparam logic        MODE_DEC    = 1'b1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;
  int                   mismatches;
  int                   pending;
  int                   words_sent = 0;
  bit                   gaps_on = 1'b0;
  bit                   stalls_on = 1'b0;
  int                   quiet_cycles = 0;
  int                   rx_hold = 0;

  xxtea_in_if  req_if ();
  xxtea_out_if res_if ();

  xxtea_block_cipher #(.MAX_WORDS(CAP)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  xxtea_result_checker #(.MAX_WORDS(CAP)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_if),
    .res          (res_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Give up when no request and no result moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side back-pressure in bursts
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        res_if.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        rx_hold = $urandom_range(1, 8) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Write all four key words on back-to-back cycles
  task automatic load_key(input logic [DATA_W-1:0] k0, input logic [DATA_W-1:0] k1,
                          input logic [DATA_W-1:0] k2, input logic [DATA_W-1:0] k3);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_KEY0;
    cfg_data_i <= k0;
    @(negedge clk_i);
    cfg_idx_i  <= REG_KEY1;
    cfg_data_i <= k1;
    @(negedge clk_i);
    cfg_idx_i  <= REG_KEY2;
    cfg_data_i <= k2;
    @(negedge clk_i);
    cfg_idx_i  <= REG_KEY3;
    cfg_data_i <= k3;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // One request, with an optional idle burst ahead of it
  task automatic send_word(input logic m, input logic [DATA_W-1:0] w, input logic l);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= m;
    req_if.data_word <= w;
    req_if.last_word <= l;
    do @(posedge clk_i); while (!req_if.ready);
    words_sent++;
  endtask

  // Block of len words; mode on later words is noise
  task automatic send_block(input int len, input logic m);
    logic [DATA_W-1:0] w;
    logic              wm;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          w = '0;
        end
        1: begin
          w = '1;
        end
        default: begin
          w = $urandom();
        end
      endcase
      wm = (i == 0) ? m : 1'($urandom_range(0, 1));
      send_word(wm, w, i == len - 1);
    end
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int   phase;
    int   phase_start;
    int   len;
    logic quiet;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_KEY0;
    cfg_data_i       = '0;
    req_if.valid     = 1'b0;
    req_if.mode      = MODE_ENC;
    req_if.data_word = '0;
    req_if.last_word = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-word pass-through, smallest blocks, overflow
    load_key('0, '0, '0, '0);
    send_word(MODE_DEC, '1, 1'b1);
    send_word(MODE_ENC, '0, 1'b1);
    send_word(MODE_ENC, '0, 1'b0);
    send_word(MODE_DEC, '1, 1'b1);
    send_word(MODE_DEC, 32'h8000_0001, 1'b0);
    send_word(MODE_ENC, 32'h7fff_fffe, 1'b1);
    settle();
    load_key('1, '1, '1, '1);
    // one word past capacity, and that dropped word closes the block
    for (int i = 0; i <= CAP; i++) begin
      send_word((i == 0) ? MODE_ENC : MODE_DEC, $urandom(), i == CAP);
    end

    // Random blocks, key changed between phases
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      settle();
      case (phase % 5)
        0: begin
          load_key($urandom(), $urandom(), $urandom(), $urandom());
        end
        1: begin
          load_key('0, '1, '0, '1);
        end
        2: begin
          load_key('1, $urandom(), '0, $urandom());
        end
        3: begin
          load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
        end
        default: begin
          load_key($urandom(), $urandom(), $urandom(), $urandom());
        end
      endcase
      phase++;
      phase_start = words_sent;
      while (words_sent < WORD_TARGET && words_sent - phase_start < PHASE_WORDS) begin
        quiet     = (words_sent >= QUIET_FROM);
        gaps_on   = !quiet && ($urandom_range(0, 3) != 0);
        stalls_on = !quiet && ($urandom_range(0, 3) != 0);
        // mostly short blocks, some full, a few overflowing
        case ($urandom_range(0, 9))
          6, 7: begin
            len = $urandom_range(5, CAP - 1);
          end
          8: begin
            len = CAP;
          end
          9: begin
            len = $urandom_range(CAP + 1, CAP + 4);
          end
          default: begin
            len = $urandom_range(1, 4);
          end
        endcase
        send_block(len, 1'($urandom_range(0, 1)));
      end
    end

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
